@@ src/kfit_pkg.sv @@
// ----------------------------------------------------------------------------
// kfit_pkg: shared types and constants of the keyed FIFO input table
// Holds the store geometry, opcodes, entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package kfit_pkg;

  localparam int unsigned Depth       = 64;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned AddrBits    = $clog2(Depth);
  localparam int unsigned CountBits   = $clog2(Depth + 1);
  localparam int unsigned KeyBits     = 32 + 8 + 3 + 1;
  localparam int unsigned EntryBits   = KeyBits + PayloadBits;

  typedef enum logic [2:0] {
    OpPush        = 3'd0,
    OpFind        = 3'd1,
    OpEraseAfter  = 3'd2,
    OpLatest      = 3'd3,
    OpLatestSlot  = 3'd4,
    OpLatestPair  = 3'd5,
    OpLatestConf  = 3'd6,
    OpClear       = 3'd7
  } op_e;

  typedef struct packed {
    logic [31:0]            frame;
    logic [7:0]             participant;
    logic [2:0]             slot;
    logic                   confirmed;
    logic [PayloadBits-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StWrite,
    StTrim,
    StDone
  } state_e;

endpackage

`default_nettype wire

@@ src/kfit_ram.sv @@
// ----------------------------------------------------------------------------
// kfit_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kfit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/kfit_match.sv @@
// ----------------------------------------------------------------------------
// kfit_match: shared compare unit
// Tests one stored entry against the request for the current opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module kfit_match (
  input  wire logic [2:0]    op_i,
  input  wire kfit_pkg::entry_t ent_i,
  input  wire logic [31:0]   frame_i,
  input  wire logic [7:0]    part_i,
  input  wire logic [2:0]    slot_i,
  output logic               hit_o
);
  import kfit_pkg::*;

  logic key_eq;
  logic pair_eq;

  assign pair_eq = (ent_i.slot == slot_i) && (ent_i.participant == part_i);
  assign key_eq  = pair_eq && (ent_i.frame == frame_i);

  // One compare per cycle, selected by opcode.
  always_comb begin
    case (op_e'(op_i))
      OpPush, OpFind: hit_o = key_eq;
      OpEraseAfter:   hit_o = (ent_i.frame <= frame_i);
      OpLatest:       hit_o = 1'b1;
      OpLatestSlot:   hit_o = (ent_i.slot == slot_i);
      OpLatestPair:   hit_o = pair_eq;
      OpLatestConf:   hit_o = pair_eq && ent_i.confirmed;
      default:        hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/keyed_fifo_input_table.sv @@
// ----------------------------------------------------------------------------
// keyed_fifo_input_table: insertion-ordered keyed table with FIFO eviction
// Top level: sequencer, entry RAM and the shared compare unit.
// ----------------------------------------------------------------------------
// Usage: raise start with opcode_i and its fields while busy is low; the
// transaction is taken at that edge and busy rises. The sequencer walks the
// held entries through one RAM read port, reading each entry and then
// comparing it (StRead, then StCheck); a push that appends adds a write state,
// and erase-after also writes kept entries back, packed from the oldest slot,
// through the single write port. Clear skips the scan and goes to StDone.
// The result is valid on the output ports while done_o is high for one cycle;
// busy stays high through that cycle and falls in the cycle after. The
// receiver cannot stall; each result must be taken when shown. capacity_we_i
// writes the capacity register while the block is idle; lowering it drops
// the oldest entries in the trim state, which moves only the oldest pointer and the count.
// Capacity above 64 saturates to 64.
// Reset empties the table (count and oldest pointer to zero) and sets the
// capacity to 64. The RAM contents are not cleared; only held entries are
// read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_fifo_input_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] frame_i,
  input  wire logic [7:0]  participant_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic        confirmed_in_i,
  input  wire logic [31:0] payload_in_i,
  input  wire logic        capacity_we_i,
  input  wire logic [6:0]  capacity_wdata_i,
  output logic             done_o,
  output logic             found_o,
  output logic [31:0]      frame_out_o,
  output logic [7:0]       participant_out_o,
  output logic [2:0]       slot_out_o,
  output logic             confirmed_out_o,
  output logic [31:0]      payload_out_o,
  output logic [6:0]       entry_count_o
);
  import kfit_pkg::*;

  localparam logic [CountBits-1:0] DepthCount = CountBits'(Depth);

  state_e               state_q, state_d;
  logic [CountBits-1:0] cap_q, cap_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [AddrBits-1:0]  oldest_q, oldest_d;
  logic [CountBits-1:0] idx_q, idx_d;
  logic [CountBits-1:0] kept_q, kept_d;
  logic [2:0]           op_q;
  logic [31:0]          frame_q;
  logic [7:0]           part_q;
  logic [2:0]           slot_q;
  logic                 conf_q;
  logic [31:0]          pay_q;
  entry_t               res_q, res_d;
  logic                 found_q, found_d;
  logic                 hit;
  entry_t               rd_ent;
  logic                 we;
  logic [AddrBits-1:0]  waddr, raddr;
  entry_t               wdata;
  logic                 reverse;
  logic [CountBits-1:0] logical;
  logic [CountBits-1:0] cap_eff;
  logic [AddrBits-1:0]  idx_phys;
  logic [CountBits-1:0] excess;

  // Entry store, read one per cycle.
  kfit_ram #(.Width(EntryBits), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_ent)
  );

  kfit_match u_match (
    .op_i   (op_q),
    .ent_i  (rd_ent),
    .frame_i(frame_q),
    .part_i (part_q),
    .slot_i (slot_q),
    .hit_o  (hit)
  );

  // Latest queries scan from newest to oldest.
  assign reverse  = (op_q == OpLatest) || (op_q == OpLatestSlot) ||
                    (op_q == OpLatestPair) || (op_q == OpLatestConf);
  assign logical  = reverse ? (count_q - idx_q - CountBits'(1)) : idx_q;
  assign raddr    = oldest_q + logical[AddrBits-1:0];
  assign cap_eff  = (cap_q > DepthCount) ? DepthCount : cap_q;
  assign idx_phys = oldest_q + idx_q[AddrBits-1:0];
  assign excess   = count_q - cap_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cap_q    <= DepthCount;
      count_q  <= '0;
      oldest_q <= '0;
      idx_q    <= '0;
      kept_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cap_q    <= cap_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      idx_q    <= idx_d;
      kept_q   <= kept_d;
      found_q  <= found_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q    <= opcode_i;
      frame_q <= frame_i;
      part_q  <= participant_i;
      slot_q  <= slot_i;
      conf_q  <= confirmed_in_i;
      pay_q   <= payload_in_i;
    end
    res_q <= res_d;
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cap_d    = cap_q;
    count_d  = count_q;
    oldest_d = oldest_q;
    idx_d    = idx_q;
    kept_d   = kept_q;
    found_d  = found_q;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = idx_phys;
    wdata    = rd_ent;
    case (state_q)
      StIdle: begin
        // Capacity write; the trim state then drops oldest entries in one step.
        if (capacity_we_i) begin
          cap_d = capacity_wdata_i;
          state_d = StTrim;
        end else if (start) begin
          idx_d   = '0;
          kept_d  = '0;
          found_d = 1'b0;
          res_d   = '0;
          if (opcode_i == OpClear) begin
            count_d  = '0;
            oldest_d = '0;
            state_d  = StDone;
          end else begin
            state_d = StRead;
          end
        end
      end
      StTrim: begin
        if (count_q > cap_eff) begin
          oldest_d = oldest_q + excess[AddrBits-1:0];
          count_d  = cap_eff;
        end
        state_d = StIdle;
      end
      StRead: begin
        if (idx_q >= count_q) begin
          if (op_q == OpPush) begin
            state_d = (cap_eff == '0) ? StDone : StWrite;
          end else begin
            if (op_q == OpEraseAfter) begin
              count_d = kept_q;
            end
            state_d = StDone;
          end
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        idx_d   = idx_q + CountBits'(1);
        state_d = StRead;
        if (op_q == OpEraseAfter) begin
          if (hit) begin
            we     = 1'b1;
            waddr  = oldest_q + kept_q[AddrBits-1:0];
            kept_d = kept_q + CountBits'(1);
          end
        end else if (hit) begin
          if (op_q == OpPush) begin
            we                = 1'b1;
            waddr             = raddr;
            wdata             = rd_ent;
            wdata.confirmed   = conf_q;
            wdata.payload     = pay_q;
            state_d           = StDone;
          end else begin
            found_d = 1'b1;
            res_d   = rd_ent;
            state_d = StDone;
          end
        end
      end
      StWrite: begin
        // Append as newest, evicting the oldest when full.
        we                = 1'b1;
        wdata.frame       = frame_q;
        wdata.participant = part_q;
        wdata.slot        = slot_q;
        wdata.confirmed   = conf_q;
        wdata.payload     = pay_q;
        if (count_q >= cap_eff) begin
          oldest_d = oldest_q + AddrBits'(1);
          waddr    = oldest_q + count_q[AddrBits-1:0];
        end else begin
          count_d = count_q + CountBits'(1);
          waddr   = oldest_q + count_q[AddrBits-1:0];
        end
        state_d = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy              = (state_q != StIdle);
  assign done_o            = (state_q == StDone);
  assign found_o           = found_q;
  assign frame_out_o       = found_q ? res_q.frame : '0;
  assign participant_out_o = found_q ? res_q.participant : '0;
  assign slot_out_o        = found_q ? res_q.slot : '0;
  assign confirmed_out_o   = found_q ? res_q.confirmed : 1'b0;
  assign payload_out_o     = found_q ? res_q.payload : '0;
  assign entry_count_o     = 7'(count_q);

endmodule

`default_nettype wire

@@ src/kfit_checker.sv @@
// ----------------------------------------------------------------------------
// kfit_checker: port-level checks of the keyed FIFO input table
// Bound to the top level; watches the command and result ports only.
// ----------------------------------------------------------------------------
`default_nettype none

module kfit_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [6:0] entry_count_o
);

  // Count never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= 7'd64) else $error("entry count above depth");

  // An accepted transaction makes the block busy or finishes next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !done_o |=> busy || done_o) else $error("start ignored");

  // A result strobe lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // A result is only shown while the block is still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside a busy period");

endmodule

bind keyed_fifo_input_table kfit_checker u_kfit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .entry_count_o(entry_count_o)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the keyed FIFO input table
// Drives commands in random bursts and keeps its own copy of the table. Each
// strobed result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import kfit_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  // Expected content of one result transaction.
  typedef struct {
    logic        found;
    logic [31:0] frame;
    logic [7:0]  participant;
    logic [2:0]  slot;
    logic        confirmed;
    logic [31:0] payload;
    logic [6:0]  count;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  logic [31:0] frame_i;
  logic [7:0]  participant_i;
  logic [2:0]  slot_i;
  logic        confirmed_in_i;
  logic [31:0] payload_in_i;
  logic        capacity_we_i;
  logic [6:0]  capacity_wdata_i;
  logic        done_o;
  logic        found_o;
  logic [31:0] frame_out_o;
  logic [7:0]  participant_out_o;
  logic [2:0]  slot_out_o;
  logic        confirmed_out_o;
  logic [31:0] payload_out_o;
  logic [6:0]  entry_count_o;

  // Table copy, oldest first, and the results still awaited.
  entry_t      held_entries[$];
  result_t     awaited_results[$];
  int unsigned table_capacity = 64;
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  keyed_fifo_input_table i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .frame_i          (frame_i),
    .participant_i    (participant_i),
    .slot_i           (slot_i),
    .confirmed_in_i   (confirmed_in_i),
    .payload_in_i     (payload_in_i),
    .capacity_we_i    (capacity_we_i),
    .capacity_wdata_i (capacity_wdata_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .frame_out_o      (frame_out_o),
    .participant_out_o(participant_out_o),
    .slot_out_o       (slot_out_o),
    .confirmed_out_o  (confirmed_out_o),
    .payload_out_o    (payload_out_o),
    .entry_count_o    (entry_count_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
  endtask

  // Apply one command to the table copy and return the expected result.
  function automatic result_t predict_command(input op_e op, input logic [31:0] frame,
                                              input logic [7:0] part, input logic [2:0] slot,
                                              input logic conf, input logic [31:0] pay);
    result_t res;
    entry_t  ent;
    entry_t  kept[$];
    int      hit;
    bit      match;
    res = '{default: '0};
    hit = -1;
    case (op)
      OpPush: begin
        if (table_capacity != 0) begin
          foreach (held_entries[i])
            if (hit < 0 && held_entries[i].frame == frame &&
                held_entries[i].participant == part && held_entries[i].slot == slot)
              hit = i;
          if (hit >= 0) begin
            held_entries[hit].confirmed = conf;
            held_entries[hit].payload   = pay;
          end else begin
            if (held_entries.size() >= table_capacity) held_entries.delete(0);
            ent.frame = frame;
            ent.participant = part;
            ent.slot = slot;
            ent.confirmed = conf;
            ent.payload = pay;
            held_entries = {held_entries, ent};
          end
        end
      end
      OpFind: begin
        foreach (held_entries[i])
          if (hit < 0 && held_entries[i].frame == frame &&
              held_entries[i].participant == part && held_entries[i].slot == slot)
            hit = i;
      end
      OpEraseAfter: begin
        foreach (held_entries[i])
          if (held_entries[i].frame <= frame) kept = {kept, held_entries[i]};
        held_entries = kept;
      end
      OpClear: held_entries.delete();
      default: begin
        // Latest queries scan from the newest entry backwards.
        for (int i = int'(held_entries.size()) - 1; i >= 0 && hit < 0; i--) begin
          case (op)
            OpLatest:     match = 1'b1;
            OpLatestSlot: match = held_entries[i].slot == slot;
            OpLatestPair: match = held_entries[i].slot == slot &&
                                  held_entries[i].participant == part;
            default:      match = held_entries[i].slot == slot &&
                                  held_entries[i].participant == part &&
                                  held_entries[i].confirmed;
          endcase
          if (match) hit = i;
        end
      end
    endcase
    if (hit >= 0 && (op == OpFind || op == OpLatest || op == OpLatestSlot ||
                     op == OpLatestPair || op == OpLatestConf)) begin
      res.found       = 1'b1;
      res.frame       = held_entries[hit].frame;
      res.participant = held_entries[hit].participant;
      res.slot        = held_entries[hit].slot;
      res.confirmed   = held_entries[hit].confirmed;
      res.payload     = held_entries[hit].payload;
    end
    res.count = 7'(held_entries.size());
    return res;
  endfunction

  // Check every strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no expectation waiting", $realtime);
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        checked_count++;
        if (found_o !== want.found)
          report_mismatch("found", 32'(found_o), 32'(want.found));
        if (frame_out_o !== want.frame) report_mismatch("frame", frame_out_o, want.frame);
        if (participant_out_o !== want.participant)
          report_mismatch("participant", 32'(participant_out_o), 32'(want.participant));
        if (slot_out_o !== want.slot)
          report_mismatch("slot", 32'(slot_out_o), 32'(want.slot));
        if (confirmed_out_o !== want.confirmed)
          report_mismatch("confirmed", 32'(confirmed_out_o), 32'(want.confirmed));
        if (payload_out_o !== want.payload)
          report_mismatch("payload", payload_out_o, want.payload);
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
      end
    end
  end

  // Send one command transaction; start stays high when the next one follows
  // without a gap.
  task automatic send_command(input op_e op, input logic [31:0] frame,
                              input logic [7:0] part, input logic [2:0] slot,
                              input logic conf, input logic [31:0] pay);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    frame_i        <= frame;
    participant_i  <= part;
    slot_i         <= slot;
    confirmed_in_i <= conf;
    payload_in_i   <= pay;
    do @(posedge clk_i); while (busy);
    awaited_results.insert(awaited_results.size(),
                           predict_command(op, frame, part, slot, conf, pay));
    sent_count++;
  endtask

  // Lower start and wait until every result has come back.
  task automatic drain;
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    drain();
    capacity_we_i    <= 1'b1;
    capacity_wdata_i <= value;
    @(posedge clk_i);
    capacity_we_i    <= 1'b0;
    table_capacity = (value > 64) ? 64 : value;
    while (held_entries.size() > table_capacity) held_entries.delete(0);
  endtask

  // Directed cases: field extremes, every opcode and the corner behaviors.
  task automatic test_directed;
    write_capacity(7'd64);
    send_command(OpLatest, 32'h0, 8'h0, 3'd0, 1'b0, 32'h0);
    send_command(OpPush, 32'h0, 8'h00, 3'd0, 1'b0, 32'h0);
    send_command(OpPush, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_command(OpPush, 32'h5, 8'h12, 3'd3, 1'b1, 32'hA5A5_5A5A);
    send_command(OpPush, 32'h6, 8'h12, 3'd3, 1'b0, 32'h1234_5678);
    send_command(OpFind, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b0, 32'h0);
    send_command(OpFind, 32'h5, 8'h13, 3'd3, 1'b0, 32'h0);
    send_command(OpPush, 32'h5, 8'h12, 3'd3, 1'b0, 32'hDEAD_BEEF);
    send_command(OpLatest, 32'h0, 8'h0, 3'd0, 1'b0, 32'h0);
    send_command(OpLatestSlot, 32'h0, 8'h0, 3'd7, 1'b0, 32'h0);
    send_command(OpLatestPair, 32'h0, 8'h12, 3'd3, 1'b0, 32'h0);
    send_command(OpLatestConf, 32'h0, 8'h12, 3'd3, 1'b0, 32'h0);
    send_command(OpLatestConf, 32'h0, 8'hFF, 3'd7, 1'b0, 32'h0);
    send_command(OpEraseAfter, 32'hFFFF_FFFF, 8'h0, 3'd0, 1'b0, 32'h0);
    send_command(OpEraseAfter, 32'h5, 8'h0, 3'd0, 1'b0, 32'h0);
    send_command(OpFind, 32'h5, 8'h12, 3'd3, 1'b0, 32'h0);
    send_command(OpClear, 32'h0, 8'h0, 3'd0, 1'b0, 32'h0);
    // Eviction of the oldest entry when the table is full.
    write_capacity(7'd2);
    send_command(OpPush, 32'h1, 8'h1, 3'd1, 1'b1, 32'h11);
    send_command(OpPush, 32'h2, 8'h1, 3'd1, 1'b1, 32'h22);
    send_command(OpPush, 32'h3, 8'h1, 3'd1, 1'b1, 32'h33);
    send_command(OpFind, 32'h1, 8'h1, 3'd1, 1'b0, 32'h0);
    // Lowering capacity drops the oldest entries; zero stores nothing.
    write_capacity(7'd1);
    send_command(OpLatest, 32'h0, 8'h0, 3'd0, 1'b0, 32'h0);
    write_capacity(7'd0);
    send_command(OpPush, 32'h9, 8'h9, 3'd1, 1'b1, 32'h99);
    // Capacity above the depth saturates.
    write_capacity(7'd127);
  endtask

  // Random commands over a small key space so that matches are frequent.
  task automatic test_random(input logic [6:0] cap, input int unsigned items);
    op_e         op;
    logic [31:0] frame;
    logic [7:0]  part;
    int unsigned pick;
    write_capacity(cap);
    for (int unsigned n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OpPush;
      else if (pick < 60) op = OpFind;
      else if (pick < 64) op = OpEraseAfter;
      else if (pick < 98) op = op_e'($urandom_range(3, 6));
      else op = OpClear;
      frame = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                          : 32'h7FFF_FFF0 + $urandom_range(0, 31);
      if (op == OpEraseAfter && $urandom_range(0, 1)) frame = 32'h7FFF_FFF0 + 
                                                          $urandom_range(16, 40);
      part = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      send_command(op, frame, part, 3'($urandom), 1'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    opcode_i         <= OpFind;
    frame_i          <= '0;
    participant_i    <= '0;
    slot_i           <= '0;
    confirmed_in_i   <= 1'b0;
    payload_in_i     <= '0;
    capacity_we_i    <= 1'b0;
    capacity_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(7'd64, 700);
    test_random(7'd5, 300);
    test_random(7'd0, 100);
    test_random(7'd1, 150);
    test_random(7'd100, 400);
    test_random(7'd20, 300);

    drain();
    repeat (150) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", awaited_results.size());
    end
    $display("Sent %0d commands over several capacities, checked %0d results.",
             sent_count, checked_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
